// ----- rtl/sx3_pkg.sv -----
// Shared types and constants of the Sobel-X 3x3 stream convolution.
// Used by every module of the block but sx3_ram; depends on nothing.
package sx3_pkg;

  localparam int PIX_W     = 16;
  localparam int VAL_W     = 20;
  localparam int CFG_W     = 11;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = 2;
  localparam int OUT_CW    = 3;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_type_t;

  typedef logic signed [PIX_W-1:0] pix_t;

  typedef struct packed {
    req_type_t req_type;
    pix_t      pixel;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last_in_frame;
  } out_item_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic row_top;
    logic row_bot;
    logic col_left;
    logic col_right;
  } pos_t;

  typedef struct packed {
    pos_t       pos;
    pix_t [2:0] left;
    pix_t [2:0] right;
  } win_t;

endpackage

// ----- rtl/sobel_3x3_stream_convolution.sv -----
// Sobel-X 3x3 stream convolution, top level: configuration, frame counters,
// line store datapath and output queue. Depends on sx3_pkg, sx3_linebuf, sx3_kernel.
//
// Usage: pixels enter in raster order on the in_ channel (valid/ready), one
// item per clock while in_ready is high. The first result leaves after
// frame_width+2 items; after the last pixel of a frame send frame_width+1
// drain items, each giving one result. out_data.last_in_frame marks the final
// result, and the next item starts a new frame. out_valid rises once the item
// that completes a result has passed the line store stage, the window stage
// and the output queue. Each item does one read and one write of the line
// store RAM, and a write to the item just read is forwarded. When out_ready
// is low, results collect in a four-entry output queue; in_ready drops once
// queued plus in-flight results would fill it, and rises again as soon as the
// receiver drains it. Reset loads frame_width and frame_height with 10,
// empties the pipeline and restarts the frame counters. A cfg_ write (only
// while idle) also restarts the frame. Line store contents need no clear:
// stale entries only ever land at positions outside the frame.
module sobel_3x3_stream_convolution
  import sx3_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int EW = (CFG_W > WW) ? CFG_W : WW;
  localparam int EH = (CFG_W > HW) ? CFG_W : HW;
  localparam int PW = $clog2(MAX_WIDTH + 3);

  logic [CFG_W-1:0] frame_width_r, frame_width_nxt;
  logic [CFG_W-1:0] frame_height_r, frame_height_nxt;
  logic [AW-1:0]    in_col_r, in_col_nxt;
  logic [AW-1:0]    out_col_r, out_col_nxt;
  logic [RW-1:0]    out_row_r, out_row_nxt;
  logic [PW-1:0]    pix_cnt_r, pix_cnt_nxt;

  logic [EW-1:0] fw_ext, fw_clamp;
  logic [EH-1:0] fh_ext, fh_clamp;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [AW-1:0] w_last;
  logic [RW-1:0] h_last;
  logic [PW-1:0] target, pix_inc;
  logic          acc;
  pos_t          pos;
  pix_t          pix;
  win_t          win;
  logic          s1_emit;
  logic          room;

  always_comb begin
    fw_ext   = EW'(frame_width_r);
    fh_ext   = EH'(frame_height_r);
    fw_clamp = (fw_ext < EW'(3)) ? EW'(3) :
               (fw_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : fw_ext;
    fh_clamp = (fh_ext < EH'(2)) ? EH'(2) :
               (fh_ext > EH'(MAX_HEIGHT)) ? EH'(MAX_HEIGHT) : fh_ext;
    eff_w    = fw_clamp[WW-1:0];
    eff_h    = fh_clamp[HW-1:0];
    w_last   = AW'(eff_w - WW'(1));
    h_last   = RW'(eff_h - HW'(1));
    target   = PW'(eff_w) + PW'(2);
    pix_inc  = (pix_cnt_r < target) ? pix_cnt_r + PW'(1) : pix_cnt_r;
  end

  always_comb begin
    acc           = in_valid && in_ready;
    pix           = (in_data.req_type == REQ_DRAIN) ? '0 : in_data.pixel;
    pos.emit      = (pix_inc == target);
    pos.last      = pos.emit && (out_row_r == h_last) && (out_col_r == w_last);
    pos.row_top   = (out_row_r != '0);
    pos.row_bot   = (out_row_r != h_last);
    pos.col_left  = (out_col_r != '0);
    pos.col_right = (out_col_r != w_last);

    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    in_col_nxt       = in_col_r;
    out_col_nxt      = out_col_r;
    out_row_nxt      = out_row_r;
    pix_cnt_nxt      = pix_cnt_r;

    if (acc) begin
      in_col_nxt  = (in_col_r == w_last) ? '0 : in_col_r + AW'(1);
      pix_cnt_nxt = pix_inc;
      if (pos.last) begin
        in_col_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        pix_cnt_nxt = '0;
      end else if (pos.emit) begin
        if (out_col_r == w_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + RW'(1);
        end else begin
          out_col_nxt = out_col_r + AW'(1);
        end
      end
    end

    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH: begin
          frame_width_nxt = cfg_wdata;
        end
        REG_FRAME_HEIGHT: begin
          frame_height_nxt = cfg_wdata;
        end
        default: begin
        end
      endcase
      in_col_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      pix_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_W'(10);
      frame_height_r <= CFG_W'(10);
      in_col_r       <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
      pix_cnt_r      <= '0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      in_col_r       <= in_col_nxt;
      out_col_r      <= out_col_nxt;
      out_row_r      <= out_row_nxt;
      pix_cnt_r      <= pix_cnt_nxt;
    end
  end

  sx3_linebuf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linebuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .pix     (pix),
    .addr    (in_col_r),
    .pos     (pos),
    .win     (win),
    .s1_emit (s1_emit)
  );

  sx3_kernel u_kernel (
    .clk       (clk),
    .rst_n     (rst_n),
    .win       (win),
    .s1_emit   (s1_emit),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .room      (room)
  );

  assign in_ready = room;

endmodule

// ----- rtl/sx3_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module sx3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/sx3_linebuf.sv -----
// Line store (both previous rows in one RAM word) with read-modify-write,
// write forwarding and the 3x3 window. Depends on sx3_pkg and sx3_ram.
module sx3_linebuf
  import sx3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  pix_t                         pix,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  pos_t                         pos,
  output win_t                         win,
  output logic                         s1_emit
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int DW = 2 * PIX_W;

  logic          s1_vld_r;
  pos_t          s1_pos_r;
  pix_t          s1_pix_r;
  logic [AW-1:0] s1_addr_r;
  logic          fwd_r;
  logic [DW-1:0] fwd_data_r;
  logic          s2_vld_r;
  pos_t          s2_pos_r;
  pix_t [2:0][2:0] win_r;

  logic [DW-1:0] rd_data;
  logic [DW-1:0] rd_sel;
  logic [DW-1:0] wdata;
  pix_t [2:0]    col_new;
  logic          fwd_nxt;

  sx3_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk     (clk),
    .we      (s1_vld_r),
    .waddr   (s1_addr_r),
    .wdata   (wdata),
    .raddr   (addr),
    .rd_data (rd_data)
  );

  always_comb begin
    rd_sel     = fwd_r ? fwd_data_r : rd_data;
    col_new[0] = rd_sel[DW-1:PIX_W];
    col_new[1] = rd_sel[PIX_W-1:0];
    col_new[2] = s1_pix_r;
    wdata      = {col_new[1], s1_pix_r};
    fwd_nxt    = acc && s1_vld_r && (s1_addr_r == addr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      s1_vld_r <= acc;
      s2_vld_r <= s1_vld_r && s1_pos_r.emit;
      fwd_r    <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pos_r   <= pos;
      s1_pix_r   <= pix;
      s1_addr_r  <= addr;
      fwd_data_r <= wdata;
    end
    if (s1_vld_r) begin
      s2_pos_r <= s1_pos_r;
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
        win_r[r][2] <= col_new[r];
      end
    end
  end

  always_comb begin
    win          = '0;
    win.pos      = s2_pos_r;
    win.pos.emit = s2_vld_r;
    for (int r = 0; r < 3; r++) begin
      win.left[r]  = win_r[r][0];
      win.right[r] = win_r[r][2];
    end
  end

  assign s1_emit = s1_vld_r && s1_pos_r.emit;

endmodule

// ----- rtl/sx3_kernel.sv -----
// Sobel-X sum over the masked window and the output item queue.
// Depends on sx3_pkg.
module sx3_kernel
  import sx3_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  win_t      win,
  input  logic      s1_emit,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data,
  output logic      room
);

  out_item_t          fifo_r [OUT_DEPTH];
  logic [OUT_AW-1:0]  wptr_r, wptr_nxt;
  logic [OUT_AW-1:0]  rptr_r, rptr_nxt;
  logic [OUT_CW-1:0]  cnt_r, cnt_nxt;
  logic [OUT_CW-1:0]  occ;

  logic signed [PIX_W:0]   d [3];
  logic signed [VAL_W-1:0] sum;
  logic                    row_en [3];
  logic                    push, pop;
  out_item_t               item;

  always_comb begin
    row_en[0] = win.pos.row_top;
    row_en[1] = 1'b1;
    row_en[2] = win.pos.row_bot;
    for (int r = 0; r < 3; r++) begin
      d[r] = '0;
      if (row_en[r] && win.pos.col_right) begin
        d[r] = d[r] + (PIX_W+1)'($signed(win.right[r]));
      end
      if (row_en[r] && win.pos.col_left) begin
        d[r] = d[r] - (PIX_W+1)'($signed(win.left[r]));
      end
    end
    sum = VAL_W'(d[0]) + (VAL_W'(d[1]) <<< 1) + VAL_W'(d[2]);
    item.value         = sum;
    item.last_in_frame = win.pos.last;
  end

  always_comb begin
    push      = win.pos.emit;
    out_valid = (cnt_r != '0);
    pop       = out_valid && out_ready;
    wptr_nxt  = push ? wptr_r + OUT_AW'(1) : wptr_r;
    rptr_nxt  = pop ? rptr_r + OUT_AW'(1) : rptr_r;
    cnt_nxt   = cnt_r + OUT_CW'(push) - OUT_CW'(pop);
    occ       = cnt_r + OUT_CW'(s1_emit) + OUT_CW'(win.pos.emit);
    room      = (occ < OUT_CW'(OUT_DEPTH));
    out_data  = fifo_r[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= item;
    end
  end

endmodule

// ----- rtl/sx3_checker.sv -----
// Port-level checks of the Sobel-X stream convolution, bound to the top level.
// Depends on sx3_pkg and sobel_3x3_stream_convolution.
module sx3_checker
  import sx3_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result item present right after reset");

  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 3))
    else $error("result item without an item taken three clocks before");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result item waiting");

endmodule

bind sobel_3x3_stream_convolution sx3_checker u_sx3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
